@@ sv/masked_ipv4_filter_table_core_defines.svh @@
// Assertion macros used by the filter table core.
`ifndef MASKED_IPV4_FILTER_TABLE_CORE_DEFINES_SVH
`define MASKED_IPV4_FILTER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MIFT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("filter table check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MIFT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("filter table check failed");

`endif

@@ sv/mift_pkg.sv @@
// Package with the constants, types and helper functions of the filter table.
`timescale 1ns / 1ps
`default_nettype none

package mift_pkg;

   localparam int ADDR_W      = 32;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 3;
   localparam int OCTET_W     = 8;
   localparam int OCTETS      = ADDR_W / OCTET_W;
   localparam int TABLE_DEPTH = 1024;
   localparam int NUM_CELLS   = (TABLE_DEPTH >= 8) ? 8 : 1;
   localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_CELLS;
   localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CELL_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W     = ADDR_W + 1;

   localparam logic [OCTET_W-1:0] OCTET_ONES = 8'hFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_CHECK  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      TOK_SWEEP = 2'd0,
      TOK_WRITE = 2'd1,
      TOK_CLEAR = 2'd2
   } tok_kind_type;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'd0,
      S_IDLE   = 3'd1,
      S_SWEEP  = 3'd2,
      S_DRAIN  = 3'd3,
      S_DECIDE = 3'd4,
      S_REPLY  = 3'd5
   } ctrl_state_type;

   // One token travels down the cell row per cycle and collects the sweep result.
   typedef struct packed {
      logic                  valid;
      tok_kind_type          kind;
      logic [ACTION_W-1:0]   op;
      logic [ROW_W-1:0]      row;
      logic [CELL_W-1:0]     pos;
      logic [CELL_W-1:0]     dst;
      logic [ADDR_W-1:0]     key;
      logic                  hit;
      logic                  free_found;
      logic [CELL_W-1:0]     free_pos;
      logic [ROW_W-1:0]      free_row;
   } tok_type;

   // A zero octet in a pattern is a wildcard; any other octet must match exactly.
   function automatic logic [ADDR_W-1:0] pattern_mask(input logic [ADDR_W-1:0] pat);
      logic [ADDR_W-1:0] m;
      m = '0;
      for (int k = 0; k < OCTETS; k++) begin
         if (pat[k*OCTET_W +: OCTET_W] != '0) begin
            m[k*OCTET_W +: OCTET_W] = OCTET_ONES;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ sv/mift_if.sv @@
// Handshake interfaces for the request and response channels of the filter table.
`timescale 1ns / 1ps
`default_nettype none

interface mift_req_if import mift_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, action, address, input ready);
   modport sink (input valid, action, address, output ready);
endinterface

interface mift_rsp_if import mift_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                blocked;
   logic [STATUS_W-1:0] status;

   modport source (output valid, blocked, status, input ready);
   modport sink (input valid, blocked, status, output ready);
endinterface

`default_nettype wire

@@ sv/mift_cell.sv @@
// One cell of the table row: a bank of entries, a token stage and the compare logic.
`timescale 1ns / 1ps
`default_nettype none

module mift_cell import mift_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  tok_type      tok_in,
   output tok_type      tok_out
);

   // Each word holds the valid bit on top of the 32-bit pattern.
   logic [ENTRY_W-1:0] bank_ff [BANK_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   tok_type            tok_ff;

   logic               entry_valid;
   logic [ADDR_W-1:0]  entry_pat;
   logic               is_equal;
   logic               is_match;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   // The read address comes with the incoming token, so the data lines up with tok_ff.
   always_ff @(posedge clock) begin
      rd_ff <= bank_ff[tok_in.row];
      if (wr_en) begin
         bank_ff[tok_ff.row] <= wr_data;
      end
   end

   assign entry_valid = rd_ff[ENTRY_W-1];
   assign entry_pat   = rd_ff[ADDR_W-1:0];
   assign is_equal    = entry_valid && (entry_pat == tok_ff.key);
   assign is_match    = entry_valid && ((tok_ff.key & pattern_mask(entry_pat)) == entry_pat);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      if (tok_ff.valid) begin
         case (tok_ff.kind)
            TOK_SWEEP: begin
               if (tok_ff.op == ACT_REMOVE && is_equal) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b0, entry_pat};
               end
            end
            TOK_WRITE: begin
               if (tok_ff.dst == tok_ff.pos) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, tok_ff.key};
               end
            end
            TOK_CLEAR: begin
               wr_en = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      tok_out     = tok_ff;
      tok_out.pos = tok_ff.pos + CELL_W'(1);
      if (tok_ff.kind == TOK_SWEEP) begin
         if (tok_ff.op == ACT_CHECK) begin
            tok_out.hit = tok_ff.hit | is_match;
         end else begin
            tok_out.hit = tok_ff.hit | is_equal;
         end
         if (!tok_ff.free_found && !entry_valid) begin
            tok_out.free_found = 1'b1;
            tok_out.free_pos   = tok_ff.pos;
            tok_out.free_row   = tok_ff.row;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/masked_ipv4_filter_table_core.sv @@
// Top level of the IPv4 filter table: controller, cell row and response register.
//
//   channel   direction  payload                 moves a word when
//   req_ch    in         action, address         req_ch.valid and req_ch.ready
//   rsp_ch    out        blocked, status         rsp_ch.valid and rsp_ch.ready
//   csr       in         csr_wr_data (ban mode)  csr_wr_en
//
// Add, remove and check sweep all BANK_DEPTH rows through the row of NUM_CELLS cells.
// An add to a full table and the unused action code skip the sweep and go straight to S_REPLY.
// After reset a clearing pass writes BANK_DEPTH rows before req_ch.ready.
// One word is worked on at a time; a finished response waits in its own register,
// so a new word is taken while rsp_ch is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_ipv4_filter_table_core_defines.svh"

module masked_ipv4_filter_table_core import mift_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   mift_req_if.sink    req_ch,
   mift_rsp_if.source  rsp_ch,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);

   ctrl_state_type      state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ACTION_W-1:0] op_ff, op_in;
   logic [ADDR_W-1:0]   key_ff, key_in;
   logic                acc_hit_ff, acc_hit_in;
   logic                acc_free_ff, acc_free_in;
   logic [CELL_W-1:0]   acc_pos_ff, acc_pos_in;
   logic [ROW_W-1:0]    acc_row_ff, acc_row_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                ban_ff;
   logic                res_blocked_ff, res_blocked_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   tok_type             issue_ff, issue_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_blocked_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_load;
   logic                req_take;
   logic                last_row;
   tok_type             chain [NUM_CELLS+1];
   tok_type             tail;
   logic                tail_sweep;

   assign chain[0]   = issue_ff;
   assign tail       = chain[NUM_CELLS];
   assign tail_sweep = tail.valid && (tail.kind == TOK_SWEEP);

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      mift_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[c]),
         .tok_out (chain[c+1])
      );
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign req_take       = req_ch.valid && req_ch.ready;
   assign last_row       = (row_ff == ROW_W'(BANK_DEPTH - 1));
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.blocked = rsp_blocked_ff;
   assign rsp_ch.status  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         row_ff         <= '0;
         count_ff       <= '0;
         ban_ff         <= 1'b1;
         issue_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ban_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      acc_hit_ff    <= acc_hit_in;
      acc_free_ff   <= acc_free_in;
      acc_pos_ff    <= acc_pos_in;
      acc_row_ff    <= acc_row_in;
      res_blocked_ff <= res_blocked_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_blocked_ff <= res_blocked_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      acc_hit_in     = acc_hit_ff;
      acc_free_in    = acc_free_ff;
      acc_pos_in     = acc_pos_ff;
      acc_row_in     = acc_row_ff;
      count_in       = count_ff;
      res_blocked_in = res_blocked_ff;
      res_status_in  = res_status_ff;
      issue_in       = '0;
      issue_in.kind  = TOK_SWEEP;
      issue_in.op    = op_ff;
      issue_in.key   = key_ff;
      issue_in.row   = row_ff;
      rsp_load       = 1'b0;

      // Fold each sweep token that leaves the last cell into the running result.
      if (tail_sweep) begin
         acc_hit_in = acc_hit_ff | tail.hit;
         if (!acc_free_ff && tail.free_found) begin
            acc_free_in = 1'b1;
            acc_pos_in  = tail.free_pos;
            acc_row_in  = tail.free_row;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            issue_in.valid = 1'b1;
            issue_in.kind  = TOK_CLEAR;
            if (last_row) begin
               row_in   = '0;
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in          = req_ch.action;
               key_in         = req_ch.address;
               acc_hit_in     = 1'b0;
               acc_free_in    = 1'b0;
               row_in         = '0;
               res_blocked_in = 1'b0;
               res_status_in  = ST_OK;
               case (req_ch.action)
                  ACT_ADD: begin
                     if (count_ff >= COUNT_W'(TABLE_DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_SWEEP;
                     end
                  end
                  ACT_REMOVE: begin
                     state_in = S_SWEEP;
                  end
                  ACT_CHECK: begin
                     state_in = S_SWEEP;
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            issue_in.valid = 1'b1;
            if (last_row) begin
               state_in = S_DRAIN;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_DRAIN: begin
            if (tail_sweep && tail.row == ROW_W'(BANK_DEPTH - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_REPLY;
            case (op_ff)
               ACT_ADD: begin
                  if (acc_hit_ff) begin
                     res_status_in = ST_DUP;
                  end else if (!acc_free_ff) begin
                     res_status_in = ST_FULL;
                  end else begin
                     issue_in.valid = 1'b1;
                     issue_in.kind  = TOK_WRITE;
                     issue_in.row   = acc_row_ff;
                     issue_in.dst   = acc_pos_ff;
                     count_in       = count_ff + COUNT_W'(1);
                     res_status_in  = ST_OK;
                  end
               end
               ACT_REMOVE: begin
                  // The table never holds two equal patterns, so one entry at most goes.
                  if (acc_hit_ff) begin
                     res_status_in = ST_REMOVED;
                     count_in      = count_ff - COUNT_W'(1);
                  end else begin
                     res_status_in = ST_NOTFOUND;
                  end
               end
               ACT_CHECK: begin
                  res_blocked_in = ban_ff ? acc_hit_ff : !acc_hit_ff;
                  res_status_in  = ST_OK;
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   `MIFT_ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= COUNT_W'(TABLE_DEPTH))
   `MIFT_ASSERT_NEXT(a_take_leaves_idle, req_take, state_ff != S_IDLE)
   `MIFT_ASSERT_IMPLY(a_sweep_tail_state, tail_sweep, state_ff == S_SWEEP || state_ff == S_DRAIN)
   `MIFT_ASSERT_NEXT(a_load_from_reply, rsp_load, rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
